// ----- hdl/ksr_pkg.sv -----
// shared constants, state codes and control structs of the k-group stream reverser
package ksr_pkg;

   localparam int MAX_GROUP = 64;
   localparam int DATA_W    = 32;
   localparam int SIZE_W    = 7;
   localparam int ADDR_W    = $clog2(MAX_GROUP);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // take the input word and store it
      logic read;     // fetch the next buffered word into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;     // the word being offered completes the group
      logic last;     // output register holds the last word of the run
   } status_type;

endpackage

// ----- hdl/ksr_ctrl.sv -----
// controller state machine: input acceptance and group drain sequencing
module ksr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_is_final,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ksr_pkg::status_type status,
   output ksr_pkg::cmd_type    cmd
);

   ksr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.read   = 1'b0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ksr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.full || req_is_final) begin
                  state_in = ksr_pkg::ST_FETCH;
               end
            end
         end
         ksr_pkg::ST_FETCH: begin
            cmd.read = 1'b1;
            state_in = ksr_pkg::ST_SEND;
         end
         ksr_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ksr_pkg::ST_IDLE;
               end else begin
                  cmd.read = 1'b1;
               end
            end
         end
         default: begin
            state_in = ksr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (status.full || req_is_final))
         |=> (state_ff == ksr_pkg::ST_FETCH))
      else $error("completed group did not start draining");

   a_fetch_then_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksr_pkg::ST_FETCH) |=> (state_ff == ksr_pkg::ST_SEND))
      else $error("fetch not followed by send");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && status.last) |=> (state_ff == ksr_pkg::ST_IDLE))
      else $error("run did not end after last word");

   a_hold_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> (!cmd.read && !req_ready))
      else $error("output register overwritten while stalled");

endmodule

// ----- hdl/ksr_dp.sv -----
// datapath: group buffer, fill count, group size register and drain address logic
module ksr_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [ksr_pkg::SIZE_W-1:0]      csr_group_size,
   input  logic signed [ksr_pkg::DATA_W-1:0] req_item_value,
   input  logic                            req_is_final,
   input  ksr_pkg::cmd_type                cmd,
   output ksr_pkg::status_type             status,
   output logic signed [ksr_pkg::DATA_W-1:0] rsp_out_value,
   output logic                            rsp_run_last,
   output logic                            rsp_list_end
);

   logic [ksr_pkg::DATA_W-1:0] store_ff [ksr_pkg::MAX_GROUP];
   logic [ksr_pkg::DATA_W-1:0] rd_data_ff;
   logic                       rd_last_ff;

   logic [ksr_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ksr_pkg::ADDR_W-1:0] fill_ff, fill_in;
   logic [ksr_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [ksr_pkg::ADDR_W-1:0] left_ff, left_in;
   logic                       rev_ff, rev_in;
   logic                       fin_ff, fin_in;

   logic [ksr_pkg::SIZE_W-1:0] eff_size;
   logic [ksr_pkg::ADDR_W:0]   count;

   // zero acts as one, oversize saturates
   always_comb begin
      priority if (size_ff == '0) begin
         eff_size = ksr_pkg::SIZE_W'(1);
      end else if (size_ff > ksr_pkg::SIZE_W'(ksr_pkg::MAX_GROUP)) begin
         eff_size = ksr_pkg::SIZE_W'(ksr_pkg::MAX_GROUP);
      end else begin
         eff_size = size_ff;
      end
   end

   assign count       = {1'b0, fill_ff} + (ksr_pkg::ADDR_W + 1)'(1);
   assign status.full = (ksr_pkg::SIZE_W'(count) >= eff_size);
   assign status.last = rd_last_ff;

   always_comb begin
      size_in = csr_valid ? csr_group_size : size_ff;
      fill_in = fill_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      rev_in  = rev_ff;
      fin_in  = fin_ff;
      if (cmd.accept) begin
         fill_in = (status.full || req_is_final) ? '0 : count[ksr_pkg::ADDR_W-1:0];
         addr_in = status.full ? fill_ff : '0;
         left_in = fill_ff;
         rev_in  = status.full;
         fin_in  = req_is_final;
      end else if (cmd.read) begin
         addr_in = rev_ff ? addr_ff - ksr_pkg::ADDR_W'(1) : addr_ff + ksr_pkg::ADDR_W'(1);
         left_in = left_ff - ksr_pkg::ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= ksr_pkg::SIZE_W'(1);
         fill_ff <= '0;
      end else begin
         size_ff <= size_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      left_ff <= left_in;
      rev_ff  <= rev_in;
      fin_ff  <= fin_in;
   end

   // group buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_ff[fill_ff] <= req_item_value;
      end
      if (cmd.read) begin
         rd_data_ff <= store_ff[addr_ff];
         rd_last_ff <= (left_ff == '0);
      end
   end

   assign rsp_out_value = rd_data_ff;
   assign rsp_run_last  = rd_last_ff;
   assign rsp_list_end  = rd_last_ff & fin_ff;

endmodule

// ----- hdl/k_group_stream_reverser.sv -----
// top level of the k-group stream reverser
// Words enter on req_, one per cycle while req_ready is high, and are held in a
// 64-word group buffer until the group is complete (fill reaches the effective
// group size) or a word flagged req_is_final arrives. A complete group leaves on
// rsp_ newest first; a short group closed by the final word leaves in arrival
// order. rsp_run_last marks the last word of every run, rsp_list_end the last
// word of the list. A word that does not close a group leaves the controller
// idle and ready for the next word. A word that closes a group of n words is
// accepted, then come the buffer fetch and the n output words, one per cycle
// while rsp_ready is high; req_ready is low during the drain, since the single
// read port of the buffer and the output register are busy.
// The group size register (0 acts as 1, above 64 saturates to 64) resets to 1
// and is written through csr_, which is always ready; write it only when idle.
// There is no clearing pass after reset: the buffer is only read where written.
module k_group_stream_reverser (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ksr_pkg::SIZE_W-1:0]        csr_group_size,
   // input words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ksr_pkg::DATA_W-1:0] req_item_value,
   input  logic                              req_is_final,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ksr_pkg::DATA_W-1:0] rsp_out_value,
   output logic                              rsp_run_last,
   output logic                              rsp_list_end
);

   ksr_pkg::cmd_type    cmd;
   ksr_pkg::status_type status;

   // register writes take effect on the next cycle
   assign csr_ready = 1'b1;

   // sequencing of accept, fetch and send
   ksr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_final (req_is_final),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   // buffer, counters and output register
   ksr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_group_size (csr_group_size),
      .req_item_value (req_item_value),
      .req_is_final   (req_is_final),
      .cmd            (cmd),
      .status         (status),
      .rsp_out_value  (rsp_out_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_list_end   (rsp_list_end)
   );

endmodule
